/* rtl/pixel_saturation_gamma_adjust_top_assert.svh */
// Assertion macros for the pixel saturation and gamma adjust block.
`ifndef PIXEL_SATURATION_GAMMA_ADJUST_TOP_ASSERT_SVH
`define PIXEL_SATURATION_GAMMA_ADJUST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PSGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSGA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSGA_ASSERT(lbl, prop, msg)
`define PSGA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/psga_pkg.sv */
// Types and constants shared by the pixel saturation and gamma adjust block.
package psga_pkg;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [16:0] LUMA_WR = 17'd19595;
  localparam logic [16:0] LUMA_WG = 17'd38470;
  localparam logic [16:0] LUMA_WB = 17'd7471;

  localparam logic signed [12:0] SAT_ONE   = 13'sd256;
  localparam logic signed [12:0] SAT_LIMIT = 13'sd3840;

  typedef logic signed [12:0] psga_sat_t;
  typedef logic [23:0] psga_luma_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] table_index;
    logic [7:0] table_value;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } psga_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } psga_out_t;

  typedef struct packed {
    logic       valid;
    logic       mode;
    logic [7:0] table_index;
    logic [7:0] table_value;
  } psga_ctl_t;

endpackage

/* rtl/pixel_saturation_gamma_adjust_top.sv */
// Top level of the pixel saturation and gamma adjust block.
//
// Input channel in_valid / in_stall / in_data carries one word per cycle unless
// stalled: either a gamma table write (mode 0, table_index and table_value) or a
// pixel (mode 1, blue, green and red bytes). A table write yields no output word.
// Output channel out_valid / out_stall / out_data carries one RGB word per pixel.
// cfg_we / cfg_wdata write the signed Q4.8 saturation; write only while idle.
//
// Three-stage pipeline: luma, per-channel adjust in three lanes, then table
// lookup into the output register. A pixel passes the luma, adjust and output
// registers in turn before it reaches out_valid. Throughput is one word per
// cycle while out_stall does not hold the pipeline; each lane holds its own
// table copy so all three lookups happen in the same cycle.
//
// Reset clears the pipeline valids and sets saturation to 1.0; the gamma table
// is not cleared and must be written before use. When out_stall is high with a
// word waiting, the whole pipeline holds and in_stall rises in the same cycle.
`include "pixel_saturation_gamma_adjust_top_assert.svh"
module pixel_saturation_gamma_adjust_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psga_pkg::psga_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output psga_pkg::psga_out_t out_data,
  input  logic                cfg_we,
  input  psga_pkg::psga_sat_t cfg_wdata
);

  logic                 adv;
  psga_pkg::psga_sat_t  sat_r;
  psga_pkg::psga_sat_t  sat_lim;
  logic                 bypass;
  psga_pkg::psga_ctl_t  s1_ctl_nxt;
  psga_pkg::psga_ctl_t  s1_ctl_r;
  psga_pkg::psga_ctl_t  s2_ctl_r;
  logic                 out_valid_r;
  logic [7:0]           blue_s1;
  logic [7:0]           green_s1;
  logic [7:0]           red_s1;
  psga_pkg::psga_luma_t luma_s1;
  logic [7:0]           map_red;
  logic [7:0]           map_green;
  logic [7:0]           map_blue;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= psga_pkg::SAT_ONE;
    end else if (cfg_we) begin
      sat_r <= cfg_wdata;
    end
  end

  always_comb begin
    bypass = (sat_r == psga_pkg::SAT_ONE);
    if (sat_r > psga_pkg::SAT_LIMIT) begin
      sat_lim = psga_pkg::SAT_LIMIT;
    end else if (sat_r < -psga_pkg::SAT_LIMIT) begin
      sat_lim = -psga_pkg::SAT_LIMIT;
    end else begin
      sat_lim = sat_r;
    end
  end

  always_comb begin
    s1_ctl_nxt.valid       = in_valid;
    s1_ctl_nxt.mode        = in_data.mode;
    s1_ctl_nxt.table_index = in_data.table_index;
    s1_ctl_nxt.table_value = in_data.table_value;
  end

  // advance control through the stages; drop table writes at the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r    <= '0;
      s2_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_ctl_r    <= s1_ctl_nxt;
      s2_ctl_r    <= s1_ctl_r;
      out_valid_r <= s2_ctl_r.valid && (s2_ctl_r.mode == psga_pkg::MODE_PIXEL);
    end
  end

  psga_luma u_luma (
    .clk     (clk),
    .adv     (adv),
    .blue    (in_data.in_blue),
    .green   (in_data.in_green),
    .red     (in_data.in_red),
    .blue_r  (blue_s1),
    .green_r (green_s1),
    .red_r   (red_s1),
    .luma_r  (luma_s1)
  );

  psga_lane u_lane_red (
    .clk     (clk),
    .adv     (adv),
    .chan    (red_s1),
    .luma    (luma_s1),
    .sat_lim (sat_lim),
    .bypass  (bypass),
    .ctl_s2  (s2_ctl_r),
    .map_r   (map_red)
  );

  psga_lane u_lane_green (
    .clk     (clk),
    .adv     (adv),
    .chan    (green_s1),
    .luma    (luma_s1),
    .sat_lim (sat_lim),
    .bypass  (bypass),
    .ctl_s2  (s2_ctl_r),
    .map_r   (map_green)
  );

  psga_lane u_lane_blue (
    .clk     (clk),
    .adv     (adv),
    .chan    (blue_s1),
    .luma    (luma_s1),
    .sat_lim (sat_lim),
    .bypass  (bypass),
    .ctl_s2  (s2_ctl_r),
    .map_r   (map_blue)
  );

  assign out_valid          = out_valid_r;
  assign out_data.out_red   = map_red;
  assign out_data.out_green = map_green;
  assign out_data.out_blue  = map_blue;

  `PSGA_ASSERT(a_write_no_word, (adv && s2_ctl_r.valid && (s2_ctl_r.mode == psga_pkg::MODE_WRITE)) |=> !out_valid_r, "table write produced an output word")
  `PSGA_ASSERT(a_pixel_word, (adv && s2_ctl_r.valid && (s2_ctl_r.mode == psga_pkg::MODE_PIXEL)) |=> out_valid_r, "pixel did not reach the output")
  `PSGA_ASSERT(a_hold_pipe, !adv |=> ($stable(s1_ctl_r) && $stable(s2_ctl_r)), "pipeline moved while stalled")
  `PSGA_ASSERT_RST(a_reset_clear, !rst_n |=> (!out_valid_r && !s1_ctl_r.valid && !s2_ctl_r.valid), "reset left a valid set")

endmodule

/* rtl/psga_luma.sv */
// Luma stage: registers the source channels and their Rec. 601 luma in Q8.16.
module psga_luma (
  input  logic                clk,
  input  logic                adv,
  input  logic [7:0]          blue,
  input  logic [7:0]          green,
  input  logic [7:0]          red,
  output logic [7:0]          blue_r,
  output logic [7:0]          green_r,
  output logic [7:0]          red_r,
  output psga_pkg::psga_luma_t luma_r
);

  logic [23:0]          luma_sum;
  psga_pkg::psga_luma_t luma_nxt;

  assign luma_sum = 24'(psga_pkg::LUMA_WR * 24'(red))
                  + 24'(psga_pkg::LUMA_WG * 24'(green))
                  + 24'(psga_pkg::LUMA_WB * 24'(blue));
  assign luma_nxt = luma_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      blue_r  <= blue;
      green_r <= green;
      red_r   <= red;
      luma_r  <= luma_nxt;
    end
  end

endmodule

/* rtl/psga_lane.sv */
// Channel lane: saturation adjust and clamp, then lookup in its own gamma table copy.
module psga_lane (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [7:0]           chan,
  input  psga_pkg::psga_luma_t luma,
  input  psga_pkg::psga_sat_t  sat_lim,
  input  logic                 bypass,
  input  psga_pkg::psga_ctl_t  ctl_s2,
  output logic [7:0]           map_r
);

  logic signed [25:0] diff;
  logic signed [38:0] prod;
  logic signed [39:0] total;
  logic [7:0]         adj;
  logic [7:0]         ch_nxt;
  logic [7:0]         ch_r;
  logic [7:0]         gtab [256];

  assign diff  = $signed({2'b00, chan, 16'h0000}) - $signed({2'b00, luma});
  assign prod  = sat_lim * diff;
  assign total = $signed({8'h00, luma, 8'h00}) + 40'(prod);

  always_comb begin
    if (total[39]) begin
      adj = 8'd0;
    end else if (|total[38:32]) begin
      adj = 8'd255;
    end else begin
      adj = total[31:24];
    end
    ch_nxt = bypass ? chan : adj;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch_r <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_s2.valid && (ctl_s2.mode == psga_pkg::MODE_WRITE)) begin
      gtab[ctl_s2.table_index] <= ctl_s2.table_value;
    end
    if (adv && ctl_s2.valid && (ctl_s2.mode == psga_pkg::MODE_PIXEL)) begin
      map_r <= gtab[ch_r];
    end
  end

endmodule

/* tb/tb_pixel_saturation_gamma_adjust_top.sv */
// Testbench for the pixel saturation and gamma adjust block: table writes and pixels checked.
`timescale 1ns / 1ps

module tb_pixel_saturation_gamma_adjust_top;

  localparam int CYCLE_LIMIT = 250000;
  localparam int SETTLE_CYCLES = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  psga_pkg::psga_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  psga_pkg::psga_out_t out_data;
  logic                cfg_we;
  psga_pkg::psga_sat_t cfg_wdata;

  psga_pkg::psga_sat_t cur_sat;
  logic [7:0]          gamma_lut [256];
  psga_pkg::psga_out_t expected_rgb [$];
  int                  mismatch_count;
  int                  cycle_count;
  bit                  src_gaps_on;
  bit                  sink_stall_on;

  pixel_saturation_gamma_adjust_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] adjust_lane(longint luma, longint c, longint s);
    longint diff;
    longint total;
    diff = c * 65536 - luma;
    total = luma * 256 + s * diff;
    if (total < 0) return 8'd0;
    total = total >>> 24;
    if (total > 255) return 8'd255;
    return total[7:0];
  endfunction

  function automatic psga_pkg::psga_out_t predict_rgb(psga_pkg::psga_in_t w);
    longint              s;
    longint              luma;
    longint              wr;
    longint              wg;
    longint              wb;
    longint              r;
    longint              g;
    longint              b;
    psga_pkg::psga_out_t o;
    r = w.in_red;
    g = w.in_green;
    b = w.in_blue;
    if (cur_sat != psga_pkg::SAT_ONE) begin
      wr = psga_pkg::LUMA_WR;
      wg = psga_pkg::LUMA_WG;
      wb = psga_pkg::LUMA_WB;
      s = longint'(cur_sat);
      if (s > longint'(psga_pkg::SAT_LIMIT)) s = longint'(psga_pkg::SAT_LIMIT);
      if (s < -longint'(psga_pkg::SAT_LIMIT)) s = -longint'(psga_pkg::SAT_LIMIT);
      luma = wr * r + wg * g + wb * b;
      r = adjust_lane(luma, r, s);
      g = adjust_lane(luma, g, s);
      b = adjust_lane(luma, b, s);
    end
    o.out_red   = gamma_lut[r[7:0]];
    o.out_green = gamma_lut[g[7:0]];
    o.out_blue  = gamma_lut[b[7:0]];
    return o;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic psga_pkg::psga_in_t make_pixel(logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b);
    psga_pkg::psga_in_t w;
    w.mode = psga_pkg::MODE_PIXEL;
    w.table_index = 8'($urandom);
    w.table_value = 8'($urandom);
    w.in_red = r;
    w.in_green = g;
    w.in_blue = b;
    return w;
  endfunction

  function automatic psga_pkg::psga_in_t make_write(logic [7:0] idx, logic [7:0] val);
    psga_pkg::psga_in_t w;
    w.mode = psga_pkg::MODE_WRITE;
    w.table_index = idx;
    w.table_value = val;
    w.in_red = 8'($urandom);
    w.in_green = 8'($urandom);
    w.in_blue = 8'($urandom);
    return w;
  endfunction

  // hold valid until the word is taken, then update the prediction
  task automatic send_word(psga_pkg::psga_in_t w);
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (w.mode == psga_pkg::MODE_WRITE) begin
      gamma_lut[w.table_index] = w.table_value;
    end else begin
      expected_rgb.push_back(predict_rgb(w));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_saturation(psga_pkg::psga_sat_t v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sat = v;
  endtask

  task automatic send_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        send_word(make_pixel(rand_byte(), rand_byte(), rand_byte()));
      end else begin
        send_word(make_write(8'($urandom), 8'($urandom)));
      end
    end
  endtask

  // fill every entry so no pixel reads an unwritten one
  task automatic test_table_load();
    for (int i = 0; i < 256; i++) begin
      send_word(make_write(8'(i), 8'(i * 7 + 13)));
    end
  endtask

  task automatic test_directed_pixels();
    logic [23:0] rgb [8];
    rgb = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
            24'h0000FF, 24'h808080, 24'hFFFF00, 24'h01FE7F};
    for (int i = 0; i < 8; i++) send_word(make_pixel(rgb[i][23:16], rgb[i][15:8], rgb[i][7:0]));
    send_word(make_write(8'd0, 8'd255));
    send_word(make_write(8'd255, 8'd0));
    set_saturation(psga_pkg::SAT_LIMIT);
    for (int i = 0; i < 6; i++) send_word(make_pixel(rgb[i][23:16], rgb[i][15:8], rgb[i][7:0]));
    set_saturation(-psga_pkg::SAT_LIMIT);
    for (int i = 0; i < 6; i++) send_word(make_pixel(rgb[i][23:16], rgb[i][15:8], rgb[i][7:0]));
  endtask

  task automatic test_saturation_sweep();
    psga_pkg::psga_sat_t sweep [10];
    sweep = '{13'sh1000, 13'sh0FFF, -psga_pkg::SAT_LIMIT, psga_pkg::SAT_LIMIT, 13'sd0,
              13'sd257, 13'sd255, psga_pkg::SAT_ONE, -13'sd256,
              psga_pkg::psga_sat_t'($urandom)};
    for (int p = 0; p < 10; p++) begin
      src_gaps_on = $urandom_range(0, 3) != 0;
      sink_stall_on = $urandom_range(0, 3) != 0;
      set_saturation(sweep[p]);
      send_random_mix(107);
    end
    src_gaps_on = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  // back-to-back writes and pixels so table updates race the pipeline
  task automatic test_table_rewrite();
    logic [7:0] r;
    set_saturation(psga_pkg::psga_sat_t'($urandom_range(0, 1023)));
    src_gaps_on = 1'b0;
    for (int i = 0; i < 30; i++) begin
      r = rand_byte();
      send_word(make_pixel(r, r, r));
      send_word(make_write(r, 8'($urandom)));
      send_word(make_pixel(r, r, r));
      send_word(make_write(8'($urandom), 8'($urandom)));
      send_word(make_pixel(rand_byte(), rand_byte(), rand_byte()));
    end
    src_gaps_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    set_saturation(psga_pkg::psga_sat_t'($urandom));
    src_gaps_on = 1'b0;
    sink_stall_on = 1'b0;
    send_random_mix(150);
  endtask

  initial begin
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (sink_stall_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    psga_pkg::psga_out_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rgb.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word %h", out_data);
      end else begin
        exp_w = expected_rgb.pop_front();
        if (out_data.out_red !== exp_w.out_red || out_data.out_green !== exp_w.out_green ||
            out_data.out_blue !== exp_w.out_blue) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch rgb: expected %h %h %h actual %h %h %h",
                     exp_w.out_red, exp_w.out_green, exp_w.out_blue,
                     out_data.out_red, out_data.out_green, out_data.out_blue);
          end
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= psga_pkg::SAT_ONE;
    cur_sat = psga_pkg::SAT_ONE;
    mismatch_count = 0;
    cycle_count = 0;
    src_gaps_on = 1'b1;
    sink_stall_on = 1'b1;
    foreach (gamma_lut[i]) gamma_lut[i] = 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_load();
    test_directed_pixels();
    test_saturation_sweep();
    test_table_rewrite();
    test_steady_stream();

    drain();
    if (mismatch_count == 0 && expected_rgb.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
